// ----- src/pat_pkg.sv -----
// Shared types and constants for the pending access table.
package pat_pkg;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int NUM_W    = 64;
    localparam int OFFSET_W = 4;
    localparam int LIMIT_W  = 4;
    localparam int TOTAL_W  = 4;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register map (index is paddr[2])
    localparam logic REG_BLOCK_OFFSET = 1'b0;
    localparam logic REG_PORT_LIMIT   = 1'b1;

    localparam logic [OFFSET_W-1:0] BLOCK_OFFSET_RESET = 4'd6;
    localparam logic [LIMIT_W-1:0]  PORT_LIMIT_RESET   = 4'd8;

    // Command codes
    typedef enum logic [1:0] {
        CMD_START      = 2'd0,
        CMD_END        = 2'd1,
        CMD_QUERY_NUM  = 2'd2,
        CMD_QUERY_ADDR = 2'd3
    } cmd_t;

    // Status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    // Configuration register contents
    typedef struct packed {
        logic [OFFSET_W-1:0] block_offset_bits;
        logic [LIMIT_W-1:0]  port_limit;
    } cfg_t;

    // Summary flags from the table lookup
    typedef struct packed {
        logic num_hit;
        logic addr_hit;
        logic full;
    } lookup_t;

endpackage

// ----- src/pat_cfg_regs.sv -----
// APB configuration registers: block offset width and port limit.
module pat_cfg_regs
    import pat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [OFFSET_W-1:0] block_offset_reg;
    logic [LIMIT_W-1:0]  port_limit_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes; low address bits are the byte offset within the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_offset_reg <= BLOCK_OFFSET_RESET;
            port_limit_reg   <= PORT_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_BLOCK_OFFSET: block_offset_reg <= pwdata[OFFSET_W-1:0];
                REG_PORT_LIMIT:   port_limit_reg   <= pwdata[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (paddr[2])
            REG_BLOCK_OFFSET: prdata = PDATA_W'(block_offset_reg);
            REG_PORT_LIMIT:   prdata = PDATA_W'(port_limit_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.block_offset_bits = block_offset_reg;
    assign cfg.port_limit        = port_limit_reg;

endmodule

// ----- src/pat_lookup.sv -----
// Parallel compare of all table entries plus first-free and first-match pick.
module pat_lookup
    import pat_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  logic [ENTRIES-1:0] valid,
    input  logic [ADDR_W-1:0]  entry_addr [ENTRIES],
    input  logic [NUM_W-1:0]   entry_num  [ENTRIES],
    input  logic [ADDR_W-1:0]  blk,
    input  logic [NUM_W-1:0]   num,
    output logic [ENTRIES-1:0] addr_match,
    output logic [ENTRIES-1:0] addr_first,
    output logic [ENTRIES-1:0] free_first,
    output lookup_t            flags
);

    logic [ENTRIES-1:0] num_match;
    logic [ENTRIES-1:0] free;

    // One comparator pair per entry
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cmp
        assign addr_match[i] = valid[i] && (entry_addr[i] == blk);
        assign num_match[i]  = valid[i] && (entry_num[i] == num);
    end

    // Lowest set bit isolates the lowest index
    assign free       = ~valid;
    assign free_first = free & (~free + ENTRIES'(1));
    assign addr_first = addr_match & (~addr_match + ENTRIES'(1));

    assign flags.num_hit  = |num_match;
    assign flags.addr_hit = |addr_match;
    assign flags.full     = &valid;

endmodule

// ----- src/pending_access_table_core.sv -----
// Top level of the pending access table: command register, table, result register.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  command   | start / busy         | cmd, address, access_number
//  result    | done (1-cycle strobe)| status, is_pending, may_start,
//            |                      | new_access_number, pending_total
//  config    | APB psel/penable     | paddr, pwdata, prdata, pready
//
// One command is taken every cycle; busy stays low. The result of a command
// passes through the command register and then the result register to done.
// The table lookup, entry update and admission check all sit between the
// command register and the result register. Reset clears all valid bits,
// the count and the number counter; configuration returns to 6 / 8.
// The receiver cannot stall; results are shown for exactly one cycle.
module pending_access_table_core
    import pat_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic [ADDR_W-1:0]  address,
    input  logic [NUM_W-1:0]   access_number,
    output logic               done,
    output logic [1:0]         status,
    output logic               is_pending,
    output logic               may_start,
    output logic [NUM_W-1:0]   new_access_number,
    output logic [TOTAL_W-1:0] pending_total,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int COUNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;

    cfg_t cfg;

    // Command register
    logic              in_valid_reg;
    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] blk_reg;
    logic [NUM_W-1:0]  num_reg;

    // Table state
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [ADDR_W-1:0]  entry_addr_reg [ENTRIES];
    logic [NUM_W-1:0]   entry_num_reg  [ENTRIES];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [NUM_W-1:0]   counter_reg;
    logic [NUM_W-1:0]   counter_next;

    // Result register
    logic               done_reg;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic               pending_reg;
    logic               pending_next;
    logic               may_start_reg;
    logic               may_start_next;
    logic [NUM_W-1:0]   new_num_reg;
    logic [NUM_W-1:0]   new_num_next;
    logic [TOTAL_W-1:0] total_reg;

    // Lookup results
    logic [ENTRIES-1:0] addr_match;
    logic [ENTRIES-1:0] addr_first;
    logic [ENTRIES-1:0] free_first;
    lookup_t            flags;

    logic               accept;
    logic               do_start;
    logic               do_end;
    logic [ENTRIES-1:0] set_oh;
    logic [ENTRIES-1:0] clr_oh;
    logic               still_pending;
    logic [ADDR_W-1:0]  blk_mask;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    pat_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pat_lookup #(
        .ENTRIES (ENTRIES)
    ) u_lookup (
        .valid      (valid_reg),
        .entry_addr (entry_addr_reg),
        .entry_num  (entry_num_reg),
        .blk        (blk_reg),
        .num        (num_reg),
        .addr_match (addr_match),
        .addr_first (addr_first),
        .free_first (free_first),
        .flags      (flags)
    );

    // Block address: clear the configured number of low bits
    assign blk_mask = {ADDR_W{1'b1}} << cfg.block_offset_bits;

    // Command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            blk_reg <= address & blk_mask;
            num_reg <= access_number;
        end
    end

    // Table update and result values
    always_comb
    begin
        do_start = in_valid_reg && (cmd_reg == CMD_START) && !flags.full;
        do_end   = in_valid_reg && (cmd_reg == CMD_END) && flags.addr_hit;
        set_oh   = do_start ? free_first : '0;
        clr_oh   = do_end ? addr_first : '0;

        valid_next   = (valid_reg & ~clr_oh) | set_oh;
        counter_next = do_start ? counter_reg + NUM_W'(1) : counter_reg;

        if (do_start)
            count_next = count_reg + COUNT_W'(1);
        else if (do_end)
            count_next = count_reg - COUNT_W'(1);
        else
            count_next = count_reg;

        // Matching entries left after this transfer, the new one included
        still_pending  = |((addr_match & ~clr_oh) | set_oh);
        may_start_next = (CMP_W'(count_next) < CMP_W'(cfg.port_limit)) && !still_pending;
        new_num_next   = do_start ? counter_next : '0;

        case (cmd_reg)
            CMD_START:
            begin
                status_next  = flags.full ? STATUS_FULL : STATUS_OK;
                pending_next = 1'b0;
            end
            CMD_END:
            begin
                status_next  = flags.addr_hit ? STATUS_OK : STATUS_NOT_FOUND;
                pending_next = 1'b0;
            end
            CMD_QUERY_NUM:
            begin
                status_next  = STATUS_OK;
                pending_next = flags.num_hit;
            end
            default:
            begin
                status_next  = STATUS_OK;
                pending_next = flags.addr_hit;
            end
        endcase
    end

    // Control state of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            count_reg   <= '0;
            counter_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            counter_reg <= counter_next;
            done_reg    <= in_valid_reg;
        end
    end

    // Entry payload, written only into the slot being filled
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (set_oh[i])
            begin
                entry_addr_reg[i] <= blk_reg;
                entry_num_reg[i]  <= counter_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            status_reg    <= status_next;
            pending_reg   <= pending_next;
            may_start_reg <= may_start_next;
            new_num_reg   <= new_num_next;
            total_reg     <= TOTAL_W'(count_next);
        end
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign is_pending        = pending_reg;
    assign may_start         = may_start_reg;
    assign new_access_number = new_num_reg;
    assign pending_total     = total_reg;

endmodule

// ----- src/pat_checker.sv -----
// Port-level checks on the pending access table, bound to the top level.
module pat_props
    import pat_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [1:0]        cmd,
    input logic              done,
    input logic [1:0]        status,
    input logic              is_pending,
    input logic [NUM_W-1:0]  new_access_number
);

    // Every accepted command yields one result at done
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("missing result after accepted command");

    // No result without a command
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result without accepted command");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STATUS_OK || status == STATUS_FULL ||
                  status == STATUS_NOT_FOUND))
        else $error("undefined status code");

    // A failed transfer carries no number and no pending flag
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (new_access_number == '0 && !is_pending))
        else $error("failed transfer with payload");

    // Only a start gives out an access number
    a_num_only_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd != CMD_START) |-> ##2 (new_access_number == '0))
        else $error("access number on non-start command");

endmodule

bind pending_access_table_core pat_props u_pat_props (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .cmd               (cmd),
    .done              (done),
    .status            (status),
    .is_pending        (is_pending),
    .new_access_number (new_access_number)
);
